// ----- rtl/core/ssd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ssd_pkg;

  localparam int DIGIT_COUNT = 4;
  localparam int DIGIT_W     = 2;
  localparam int TICK_W      = 17;
  localparam int LAG_W       = 16;
  localparam int ADDR_W      = 5;

  localparam logic [7:0]       PAT_ZERO  = 8'b0011_1111;
  localparam logic [7:0]       PAT_DASH  = 8'b0100_0000;
  localparam logic [7:0]       PAT_BLANK = 8'b0000_0000;
  localparam logic [7:0]       PAT_POINT = 8'b1000_0000;
  localparam logic [15:0]      MAX_SHOWN = 16'd9999;
  localparam logic [LAG_W-1:0] LAG_RESET = 16'd15000;

  // reciprocal multipliers, exact for values up to MAX_SHOWN
  localparam logic [12:0] RECIP_10   = 13'd6554;   // >> 16
  localparam logic [12:0] RECIP_100  = 13'd5243;   // >> 19
  localparam logic [14:0] RECIP_1000 = 15'd16778;  // >> 24

  // register indexes
  localparam logic [2:0] REG_REFRESH_LAG   = 3'd0;
  localparam logic [2:0] REG_DISPLAY_ON    = 3'd1;
  localparam logic [2:0] REG_SEG_ACT_LOW   = 3'd2;
  localparam logic [2:0] REG_DIGIT_EN_LVL  = 3'd3;
  localparam logic [2:0] REG_SCAN_RTL      = 3'd4;

  // item modes
  localparam logic MODE_SET  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [15:0] value;
    logic [1:0]  point_position;
  } ssd_in_t;

  typedef struct packed {
    logic [7:0]             segment_lines;
    logic [DIGIT_COUNT-1:0] digit_enables;
    logic [DIGIT_W-1:0]     scan_index;
  } ssd_out_t;

  // input word plus its decimal quotients
  typedef struct packed {
    ssd_in_t     item;
    logic [9:0]  q10;
    logic [6:0]  q100;
    logic [3:0]  q1000;
  } ssd_stage_t;

  typedef struct packed {
    logic [LAG_W-1:0] refresh_lag;
    logic             display_on;
    logic             seg_active_low;
    logic             digit_en_level;
    logic             scan_rtl;
  } ssd_cfg_t;

  function automatic logic [7:0] glyph(input logic [3:0] d);
    logic [7:0] g;
    case (d)
      4'd0:    g = 8'h3F;
      4'd1:    g = 8'h06;
      4'd2:    g = 8'h5B;
      4'd3:    g = 8'h4F;
      4'd4:    g = 8'h66;
      4'd5:    g = 8'h6D;
      4'd6:    g = 8'h7D;
      4'd7:    g = 8'h07;
      4'd8:    g = 8'h7F;
      4'd9:    g = 8'h6F;
      default: g = PAT_BLANK;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ssd_in_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ssd_in_stage (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ssd_pkg::ssd_in_t    in_data,
  input  wire logic                take,
  output logic                     stg_valid,
  output ssd_pkg::ssd_stage_t      stg_data
);

  logic                vld_r;
  ssd_pkg::ssd_stage_t word_r;
  ssd_pkg::ssd_stage_t word_nxt;
  logic [31:0]         p10;
  logic [31:0]         p100;
  logic [31:0]         p1000;
  logic                advance;

  // decimal quotients by reciprocal multiply, in parallel
  always_comb begin
    p10   = {16'd0, in_data.value} * {19'd0, ssd_pkg::RECIP_10};
    p100  = {16'd0, in_data.value} * {19'd0, ssd_pkg::RECIP_100};
    p1000 = {16'd0, in_data.value} * {17'd0, ssd_pkg::RECIP_1000};
    word_nxt.item  = in_data;
    word_nxt.q10   = p10[25:16];
    word_nxt.q100  = p100[25:19];
    word_nxt.q1000 = p1000[27:24];
  end

  assign advance  = !vld_r || take;
  assign in_ready = advance;

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (advance) begin
      vld_r <= in_valid;
    end
  end

  // word register
  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      word_r <= word_nxt;
    end
  end

  assign stg_valid = vld_r;
  assign stg_data  = word_r;

endmodule

`default_nettype wire

// ----- rtl/core/ssd_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ssd_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ssd_pkg::ssd_cfg_t   cfg,
  input  wire logic                go,
  input  wire ssd_pkg::ssd_stage_t stg_data,
  output logic                     res_push,
  output ssd_pkg::ssd_out_t        res_data
);

  localparam int ND = ssd_pkg::DIGIT_COUNT;
  localparam int DW = ssd_pkg::DIGIT_W;
  localparam int TW = ssd_pkg::TICK_W;

  logic [7:0]    pat_r [ND];
  logic [7:0]    pat_nxt [ND];
  logic [TW-1:0] tick_r;
  logic [TW-1:0] tick_nxt;
  logic [DW-1:0] step_r;
  logic [DW-1:0] step_nxt;

  logic [3:0]    dig [ND];
  logic [7:0]    q100_x10;
  logic [7:0]    q1000_x10;
  logic [10:0]   q10_x10;
  logic [7:0]    raw [ND];
  logic          is_set;
  logic          is_tick;
  logic          fire;
  logic [TW-1:0] tick_inc;
  logic [DW-1:0] digit;
  logic [ND-1:0] onehot;

  assign is_set  = go && (stg_data.item.mode == ssd_pkg::MODE_SET);
  assign is_tick = go && (stg_data.item.mode == ssd_pkg::MODE_TICK);

  // digits from quotients: remainder by shift-add times ten
  always_comb begin
    q1000_x10 = {1'b0, stg_data.q1000, 3'd0} + {3'd0, stg_data.q1000, 1'b0};
    q100_x10  = {stg_data.q100, 1'b0} + {stg_data.q100[4:0], 3'd0};
    q10_x10   = {stg_data.q10, 1'b0} + {stg_data.q10[7:0], 3'd0};
    dig[3]    = stg_data.q1000;
    dig[2]    = 4'({1'b0, stg_data.q100} - q1000_x10);
    dig[1]    = 4'(stg_data.q10[7:0] - q100_x10);
    dig[0]    = 4'(stg_data.item.value[10:0] - q10_x10);
  end

  // glyphs, leading zero blanking, point, dashes, polarity
  always_comb begin
    for (int d = 0; d < ND; d++) begin
      raw[d] = ssd_pkg::glyph(dig[d]);
    end
    if (stg_data.item.point_position == 2'd0) begin
      if (dig[3] == 4'd0) begin
        raw[3] = ssd_pkg::PAT_BLANK;
        if (dig[2] == 4'd0) begin
          raw[2] = ssd_pkg::PAT_BLANK;
          if (dig[1] == 4'd0) begin
            raw[1] = ssd_pkg::PAT_BLANK;
          end
        end
      end
    end else begin
      raw[stg_data.item.point_position] = raw[stg_data.item.point_position] |
                                          ssd_pkg::PAT_POINT;
    end
    if (stg_data.item.value > ssd_pkg::MAX_SHOWN) begin
      for (int d = 0; d < ND; d++) begin
        raw[d] = ssd_pkg::PAT_DASH;
      end
    end
    for (int d = 0; d < ND; d++) begin
      pat_nxt[d] = cfg.seg_active_low ? ~raw[d] : raw[d];
    end
  end

  // prescaler and scan
  always_comb begin
    tick_inc = tick_r + 1'b1;
    fire     = tick_inc > {1'b0, cfg.refresh_lag};
    tick_nxt = fire ? '0 : tick_inc;
    digit    = cfg.scan_rtl ? step_r : ~step_r;
    onehot   = ND'(1) << digit;
    step_nxt = step_r + 1'b1;
  end

  assign res_push = is_tick && fire && cfg.display_on;

  always_comb begin
    res_data.segment_lines = pat_r[digit];
    res_data.digit_enables = cfg.digit_en_level ? onehot : ~onehot;
    res_data.scan_index    = digit;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
      step_r <= '0;
      for (int d = 0; d < ND; d++) begin
        pat_r[d] <= '0;
      end
    end else begin
      if (is_set) begin
        for (int d = 0; d < ND; d++) begin
          pat_r[d] <= pat_nxt[d];
        end
      end
      if (is_tick) begin
        tick_r <= tick_nxt;
      end
      if (res_push) begin
        step_r <= step_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ssd_out_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ssd_out_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire ssd_pkg::ssd_out_t push_data,
  output logic                   space,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ssd_pkg::ssd_out_t      out_data
);

  logic [1:0]        cnt_r;
  logic [1:0]        cnt_nxt;
  ssd_pkg::ssd_out_t head_r;
  ssd_pkg::ssd_out_t tail_r;
  logic              pop;

  assign pop       = (cnt_r != 2'd0) && out_ready;
  assign space     = (cnt_r != 2'd2) || pop;
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = head_r;

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // two-word skid storage, head always at the output
  always_ff @(posedge clk) begin
    case (cnt_r)
      2'd0: begin
        if (push) begin
          head_r <= push_data;
        end
      end
      2'd1: begin
        if (push && pop) begin
          head_r <= push_data;
        end else if (push) begin
          tail_r <= push_data;
        end
      end
      2'd2: begin
        if (pop) begin
          head_r <= tail_r;
          if (push) begin
            tail_r <= push_data;
          end
        end
      end
      default: begin
        head_r <= head_r;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/four_digit_seven_segment_driver_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Four-digit multiplexed seven-segment driver. A set word (mode 0) converts
// value and point_position into four segment patterns and stores them; it
// gives no output. A tick word (mode 1) steps the refresh prescaler, and when
// the count passes refresh_lag with the display on, one output word carries
// the pattern, digit enables and index of the next scanned digit. One word is
// taken every cycle while the output buffer has room; a word is held in the
// input register while the conversion and scan logic works on it, and its
// result is then loaded into the output buffer, which raises out_valid.
// A two-word output buffer lets input continue while a result waits; input
// stalls only when that buffer is full.
// Registers (APB, 4-byte spacing): 0 refresh_lag, 1 display_on,
// 2 segments_active_low, 3 digit_enable_level, 4 scan_right_to_left.
// Segment polarity is applied when patterns are stored, not when they are shown.
module four_digit_seven_segment_driver_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire ssd_pkg::ssd_in_t             in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output ssd_pkg::ssd_out_t                 out_data,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ssd_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  ssd_pkg::ssd_cfg_t   cfg_r;
  ssd_pkg::ssd_stage_t stg_data;
  ssd_pkg::ssd_out_t   res_data;
  logic                stg_valid;
  logic                space;
  logic                go;
  logic                res_push;
  logic                wr_en;
  logic [2:0]          reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.refresh_lag    <= ssd_pkg::LAG_RESET;
      cfg_r.display_on     <= 1'b1;
      cfg_r.seg_active_low <= 1'b0;
      cfg_r.digit_en_level <= 1'b1;
      cfg_r.scan_rtl       <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        ssd_pkg::REG_REFRESH_LAG:  cfg_r.refresh_lag    <= pwdata[15:0];
        ssd_pkg::REG_DISPLAY_ON:   cfg_r.display_on     <= pwdata[0];
        ssd_pkg::REG_SEG_ACT_LOW:  cfg_r.seg_active_low <= pwdata[0];
        ssd_pkg::REG_DIGIT_EN_LVL: cfg_r.digit_en_level <= pwdata[0];
        ssd_pkg::REG_SCAN_RTL:     cfg_r.scan_rtl       <= pwdata[0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      ssd_pkg::REG_REFRESH_LAG:  prdata = {16'd0, cfg_r.refresh_lag};
      ssd_pkg::REG_DISPLAY_ON:   prdata = {31'd0, cfg_r.display_on};
      ssd_pkg::REG_SEG_ACT_LOW:  prdata = {31'd0, cfg_r.seg_active_low};
      ssd_pkg::REG_DIGIT_EN_LVL: prdata = {31'd0, cfg_r.digit_en_level};
      ssd_pkg::REG_SCAN_RTL:     prdata = {31'd0, cfg_r.scan_rtl};
      default:                   prdata = 32'd0;
    endcase
  end

  assign go = stg_valid && space;

  ssd_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .take      (space),
    .stg_valid (stg_valid),
    .stg_data  (stg_data)
  );

  ssd_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .go       (go),
    .stg_data (stg_data),
    .res_push (res_push),
    .res_data (res_data)
  );

  ssd_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_data),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // exactly one digit differs from the others
  a_one_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($onehot(out_data.digit_enables) || $onehot(~out_data.digit_enables)))
    else $error("digit enables not one-hot");

  // input stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // driven digit matches its enable bit
  a_index_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($countones(out_data.digit_enables) == 1) ==
                  out_data.digit_enables[out_data.scan_index])
    else $error("scan index does not match digit enables");

  // output buffer empty after reset
  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result present right after reset");

endmodule

`default_nettype wire

// ----- test/ssd_refresh_checker.sv -----
`timescale 1ns / 1ps

// watches the word channels and the register port, predicts every refresh word
// and compares it field by field against what the driver sends out
module ssd_refresh_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  ssd_pkg::ssd_in_t            in_data,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  ssd_pkg::ssd_out_t           out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [ssd_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output int                          failures,
  output int                          pending,
  output int                          set_words,
  output int                          tick_words,
  output int                          refresh_words
);
  import ssd_pkg::*;

  // shadow of the driver state
  logic [7:0]         stored_pat [DIGIT_COUNT];
  logic [TICK_W-1:0]  prescale;
  logic [DIGIT_W-1:0] scan_pos;
  ssd_cfg_t           regs;
  ssd_out_t           refresh_q [$];

  // a..g patterns of the decimal numerals
  function automatic logic [7:0] numeral_segments(input int n);
    case (n)
      0:       return 8'h3F;
      1:       return 8'h06;
      2:       return 8'h5B;
      3:       return 8'h4F;
      4:       return 8'h66;
      5:       return 8'h6D;
      6:       return 8'h7D;
      7:       return 8'h07;
      8:       return 8'h7F;
      default: return 8'h6F;
    endcase
  endfunction

  // convert a set word into the four stored patterns
  function automatic void store_number(input logic [15:0] num, input logic [1:0] dp);
    logic [7:0] pat [DIGIT_COUNT];
    int         rest;
    bit         leading;
    rest = int'(num);
    for (int d = 0; d < DIGIT_COUNT; d++) begin
      pat[d] = numeral_segments(rest % 10);
      rest = rest / 10;
    end
    // no point: blank leading zeros, digit 0 always shown
    if (dp == 2'd0) begin
      leading = 1'b1;
      for (int d = DIGIT_COUNT - 1; d >= 1; d--) begin
        if (leading && pat[d] == PAT_ZERO) begin
          pat[d] = PAT_BLANK;
        end else begin
          leading = 1'b0;
        end
      end
    end else begin
      pat[dp] = pat[dp] | PAT_POINT;
    end
    // out of range shows dashes everywhere
    if (num > MAX_SHOWN) begin
      for (int d = 0; d < DIGIT_COUNT; d++) begin
        pat[d] = PAT_DASH;
      end
    end
    // polarity is applied once, at store time
    for (int d = 0; d < DIGIT_COUNT; d++) begin
      stored_pat[d] = regs.seg_active_low ? ~pat[d] : pat[d];
    end
  endfunction

  // one tick of the prescaler, queueing a refresh word when it fires with the display on
  function automatic void advance_prescaler();
    ssd_out_t           r;
    logic [DIGIT_W-1:0] digit;
    logic [3:0]         onehot;
    prescale = prescale + 1'b1;
    if (prescale > TICK_W'(regs.refresh_lag)) begin
      prescale = '0;
      if (regs.display_on) begin
        digit = regs.scan_rtl ? scan_pos : DIGIT_W'(DIGIT_COUNT - 1) - scan_pos;
        onehot = 4'b0001 << digit;
        r.segment_lines = stored_pat[digit];
        r.digit_enables = regs.digit_en_level ? onehot : ~onehot;
        r.scan_index    = digit;
        refresh_q.push_back(r);
        scan_pos = scan_pos + 1'b1;
      end
    end
  endfunction

  // compare one refresh word against the oldest prediction
  task automatic check_refresh(input ssd_out_t got);
    ssd_out_t want;
    refresh_words++;
    if (refresh_q.size() == 0) begin
      $error("refresh word with nothing predicted: segment_lines=%02h digit_enables=%h",
             got.segment_lines, got.digit_enables);
      failures++;
    end else begin
      want = refresh_q.pop_front();
      if (got.segment_lines !== want.segment_lines) begin
        $error("segment_lines: expected %02h, actual %02h",
               want.segment_lines, got.segment_lines);
        failures++;
      end
      if (got.digit_enables !== want.digit_enables) begin
        $error("digit_enables: expected %b, actual %b",
               want.digit_enables, got.digit_enables);
        failures++;
      end
      if (got.scan_index !== want.scan_index) begin
        $error("scan_index: expected %0d, actual %0d", want.scan_index, got.scan_index);
        failures++;
      end
    end
  endtask

  // all channels are sampled at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < DIGIT_COUNT; d++) begin
        stored_pat[d] = '0;
      end
      prescale            = '0;
      scan_pos            = '0;
      regs.refresh_lag    = LAG_RESET;
      regs.display_on     = 1'b1;
      regs.seg_active_low = 1'b0;
      regs.digit_en_level = 1'b1;
      regs.scan_rtl       = 1'b0;
      refresh_q.delete();
      failures      = 0;
      set_words     = 0;
      tick_words    = 0;
      refresh_words = 0;
    end else begin
      // register writes, only low bits kept, unmapped indexes dropped
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_REFRESH_LAG:  regs.refresh_lag    = pwdata[LAG_W-1:0];
          REG_DISPLAY_ON:   regs.display_on     = pwdata[0];
          REG_SEG_ACT_LOW:  regs.seg_active_low = pwdata[0];
          REG_DIGIT_EN_LVL: regs.digit_en_level = pwdata[0];
          REG_SCAN_RTL:     regs.scan_rtl       = pwdata[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        check_refresh(out_data);
      end
      if (in_valid && in_ready) begin
        if (in_data.mode == MODE_SET) begin
          store_number(in_data.value, in_data.point_position);
          set_words++;
        end else begin
          advance_prescaler();
          tick_words++;
        end
      end
    end
    pending = refresh_q.size();
  end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import ssd_pkg::*;

  localparam int CYCLE_LIMIT     = 300000;
  localparam int TAIL_CYCLES     = 8;
  localparam int HOLD_CYCLES     = 80;
  localparam int PHASES          = 16;
  localparam int ITEMS_PER_PHASE = 118;

  // register indexes past the end of the map
  localparam logic [2:0] REG_UNMAPPED_LO = 3'd5;
  localparam logic [2:0] REG_UNMAPPED_HI = 3'd7;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  ssd_in_t           in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  ssd_out_t          out_data;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [31:0]       pwdata    = '0;
  logic [31:0]       prdata;
  logic              pready;

  int fail_cnt;
  int pending;
  int set_cnt;
  int tick_cnt;
  int refresh_cnt;
  int gap_pct      = 0;
  int stall_pct    = 0;
  int hold_asks    = 0;
  int settings_cnt = 0;
  int cycle_cnt    = 0;

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  four_digit_seven_segment_driver_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  ssd_refresh_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .failures      (fail_cnt),
    .pending       (pending),
    .set_words     (set_cnt),
    .tick_words    (tick_cnt),
    .refresh_words (refresh_cnt)
  );

  // receiver: random stalls, or a long hold when one is asked for
  initial begin
    int hold_left;
    int holds_seen;
    hold_left  = 0;
    holds_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_asks != holds_seen) begin
        holds_seen = hold_asks;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $error("timeout after %0d cycles, %0d refresh words still awaited", cycle_cnt, pending);
    $display("[four_digit_seven_segment_driver_top] ERROR");
    $finish;
  end

  // junk in bits above the register width
  function automatic logic [31:0] pad_bits(input logic [31:0] v, input int w);
    logic [31:0] junk;
    junk = ($urandom_range(1) != 0) ? ($urandom << w) : 32'h0;
    return junk | v;
  endfunction

  function automatic logic [15:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) begin
      return 16'($urandom_range(99));
    end else if (r < 70) begin
      return 16'($urandom_range(int'(MAX_SHOWN)));
    end else if (r < 82) begin
      case ($urandom_range(4))
        0:       return 16'd0;
        1:       return MAX_SHOWN;
        2:       return MAX_SHOWN + 16'd1;
        3:       return 16'd1000;
        default: return 16'hFFFF;
      endcase
    end else begin
      return 16'($urandom);
    end
  endfunction

  function automatic logic [15:0] pick_lag(input int ph);
    if (ph == 0) begin
      return 16'd0;
    end else if ($urandom_range(99) < 70) begin
      return 16'($urandom_range(3));
    end else begin
      return 16'($urandom_range(24, 4));
    end
  endfunction

  // one register write: setup then access
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_display(input logic [15:0] lag, input logic on, input logic act_low,
                                 input logic en_lvl, input logic rtl);
    reg_write(REG_REFRESH_LAG, pad_bits(32'(lag), LAG_W));
    reg_write(REG_DISPLAY_ON, pad_bits(32'(on), 1));
    reg_write(REG_SEG_ACT_LOW, pad_bits(32'(act_low), 1));
    reg_write(REG_DIGIT_EN_LVL, pad_bits(32'(en_lvl), 1));
    reg_write(REG_SCAN_RTL, pad_bits(32'(rtl), 1));
    settings_cnt++;
  endtask

  // offer one word, with random idle cycles in front
  task automatic send_word(input ssd_in_t w);
    ssd_in_t noise;
    while ($urandom_range(99) < gap_pct) begin
      noise.mode           = 1'($urandom_range(1));
      noise.value          = 16'($urandom);
      noise.point_position = 2'($urandom_range(3));
      in_valid <= 1'b0;
      in_data  <= noise;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_tick();
    ssd_in_t w;
    w.mode           = MODE_TICK;
    w.value          = 16'($urandom);
    w.point_position = 2'($urandom_range(3));
    send_word(w);
  endtask

  task automatic send_value(input logic [15:0] v, input logic [1:0] dp);
    ssd_in_t w;
    w.mode           = MODE_SET;
    w.value          = v;
    w.point_position = dp;
    send_word(w);
  endtask

  // stop offering until every predicted refresh is out, then let set words settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: slow prescaler, nothing refreshes
    send_value(16'd1234, 2'd0);
    send_tick();
    send_tick();
    wait_drained();

    // refresh on every tick, walk the numeral corner cases
    program_display(16'd0, 1'b1, 1'b0, 1'b1, 1'b0);
    send_value(16'd0, 2'd0);
    repeat (4) send_tick();
    send_value(MAX_SHOWN, 2'd2);
    send_tick();
    send_value(MAX_SHOWN + 16'd1, 2'd1);
    send_tick();
    send_value(16'hFFFF, 2'd3);
    send_value(16'd1000, 2'd0);
    send_tick();
    send_value(16'd7, 2'd1);
    send_tick();

    // polarity only flips on the next store
    wait_drained();
    reg_write(REG_SEG_ACT_LOW, 32'd1);
    send_tick();
    send_value(16'd42, 2'd0);
    send_tick();

    // active-low enables, direction reversed mid-scan
    wait_drained();
    reg_write(REG_DIGIT_EN_LVL, 32'd0);
    reg_write(REG_SCAN_RTL, 32'd1);
    send_tick();

    // display off: prescaler keeps running silently
    wait_drained();
    reg_write(REG_DISPLAY_ON, 32'd0);
    send_tick();
    send_tick();

    // longest lag, then lowered below the running count
    wait_drained();
    reg_write(REG_DISPLAY_ON, 32'd1);
    reg_write(REG_REFRESH_LAG, 32'h0000_FFFF);
    repeat (5) send_tick();
    wait_drained();
    reg_write(REG_REFRESH_LAG, 32'hABCD_0001);
    reg_write(REG_UNMAPPED_LO, $urandom);
    reg_write(REG_UNMAPPED_HI, $urandom);
    send_tick();
    send_tick();

    // random phases over all idle mixes
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph % 4)
        0: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct   = 71;
          stall_pct = 0;
        end
        2: begin
          gap_pct   = 0;
          stall_pct = 71;
        end
        default: begin
          gap_pct   = 11;
          stall_pct = 11;
        end
      endcase
      program_display(pick_lag(ph), (ph % 6) != 5, 1'($urandom_range(1)),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if ($urandom_range(99) < 80) begin
          send_tick();
        end else begin
          send_value(pick_value(), 2'($urandom_range(3)));
        end
        if ($urandom_range(149) == 0) begin
          wait_drained();
        end
      end
    end

    // long receiver hold while ticks keep coming, so the input backs up
    wait_drained();
    gap_pct   = 0;
    stall_pct = 0;
    program_display(16'd0, 1'b1, 1'($urandom_range(1)), 1'b1, 1'($urandom_range(1)));
    send_value(pick_value(), 2'($urandom_range(3)));
    hold_asks++;
    repeat (60) send_tick();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d set words and %0d tick words, %0d refresh words checked",
             set_cnt, tick_cnt, refresh_cnt);
    $display("%0d register settings, idle mixes none/sender/receiver/both, %0d long hold",
             settings_cnt, hold_asks);
    if (fail_cnt == 0 && pending == 0) begin
      $display("[four_digit_seven_segment_driver_top] OK");
    end else begin
      $display("[four_digit_seven_segment_driver_top] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/ssd_pkg.sv
rtl/core/ssd_in_stage.sv
rtl/core/ssd_core.sv
rtl/core/ssd_out_fifo.sv
rtl/core/four_digit_seven_segment_driver_top.sv
test/ssd_refresh_checker.sv
test/tb_top.sv
